// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, datapath command codes and control/status types for the
// prime two-squares decomposition block.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int PRIME_W      = 31;
   localparam int PRIME_BITS   = 31;
   localparam int ROOT_W       = 17;
   localparam int SEARCH_LIMIT = 128;
   localparam int X_W          = $clog2(SEARCH_LIMIT + 1);
   localparam int CNT_W        = $clog2(PRIME_BITS);
   localparam int TERM_W       = 32;
   localparam int NUM_W        = 64;
   localparam int DIV_CNT_W    = $clog2(NUM_W);
   localparam int OP_W         = 5;

   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_POW_INIT = 5'd2;
   localparam logic [OP_W-1:0] OP_MM_ACC   = 5'd3;
   localparam logic [OP_W-1:0] OP_MM_BASE  = 5'd4;
   localparam logic [OP_W-1:0] OP_MM_SQ    = 5'd5;
   localparam logic [OP_W-1:0] OP_SET_ACC  = 5'd6;
   localparam logic [OP_W-1:0] OP_SET_BASE = 5'd7;
   localparam logic [OP_W-1:0] OP_ROOT     = 5'd8;
   localparam logic [OP_W-1:0] OP_NEXT_X   = 5'd9;
   localparam logic [OP_W-1:0] OP_MUL      = 5'd10;
   localparam logic [OP_W-1:0] OP_SUM      = 5'd11;
   localparam logic [OP_W-1:0] OP_DIV_S    = 5'd12;
   localparam logic [OP_W-1:0] OP_DIV_A    = 5'd13;
   localparam logic [OP_W-1:0] OP_DIV_B    = 5'd14;
   localparam logic [OP_W-1:0] OP_WR_Q     = 5'd15;
   localparam logic [OP_W-1:0] OP_WR_U     = 5'd16;
   localparam logic [OP_W-1:0] OP_WR_V     = 5'd17;
   localparam logic [OP_W-1:0] OP_EMIT     = 5'd18;

   // descent term being built
   localparam logic [1:0] K_NA   = 2'd0;
   localparam logic [1:0] K_NB   = 2'd1;
   localparam logic [1:0] K_NM   = 2'd2;
   localparam logic [1:0] K_INIT = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      k;
      logic            t;
   } cmd_type;

   typedef struct packed {
      logic p_lt2;
      logic x_end;
      logic e_bit;
      logic i_last;
      logic mm_done;
      logic mm_root;
      logic div_done;
      logic m_le1;
   } sts_type;

endpackage

// ----- rtl/core/pts_modmul.sv -----
// ----------------------------------------------------------------------------
// pts_modmul
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pts_modmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pts_pkg::PRIME_BITS-1:0] modulus,
   input  logic [pts_pkg::PRIME_BITS-1:0] opa,
   input  logic [pts_pkg::PRIME_BITS-1:0] opb,
   output logic                           done,
   output logic [pts_pkg::PRIME_BITS-1:0] result
);
   import pts_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PRIME_BITS-1:0] acc_ff, acc_in;
   logic [PRIME_BITS-1:0] opa_ff, opa_in;
   logic [PRIME_BITS-1:0] mul_ff, mul_in;
   logic [PRIME_BITS:0]   dbl, red1, sum, red2;

   always_comb begin
      dbl  = {acc_ff, 1'b0};
      red1 = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum  = red1 + (mul_ff[PRIME_BITS-1] ? {1'b0, opa_ff} : '0);
      red2 = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      mul_in  = mul_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PRIME_BITS - 1);
         acc_in  = '0;
         opa_in  = opa;
         mul_in  = opb;
      end else if (busy_ff) begin
         acc_in = red2[PRIME_BITS-1:0];
         mul_in = {mul_ff[PRIME_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      mul_ff <= mul_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule

// ----- rtl/core/pts_div.sv -----
// ----------------------------------------------------------------------------
// pts_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero; remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module pts_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [pts_pkg::NUM_W-1:0] num,
   input  logic [pts_pkg::PRIME_BITS-1:0]   den,
   output logic                             done,
   output logic signed [pts_pkg::NUM_W-1:0] quo,
   output logic signed [pts_pkg::PRIME_BITS:0] rem
);
   import pts_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]      mag_ff, mag_in;
   logic [PRIME_BITS-1:0] rem_ff, rem_in;
   logic [PRIME_BITS-1:0] den_ff, den_in;
   logic [PRIME_BITS:0]   trial;
   logic                  ge;

   always_comb begin
      trial = {rem_ff, mag_ff[NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[NUM_W-1];
         mag_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         rem_in = ge ? PRIME_BITS'(trial - {1'b0, den_ff}) : trial[PRIME_BITS-1:0];
         mag_in = {mag_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -signed'(mag_ff) : signed'(mag_ff);
   assign rem  = neg_ff ? -signed'({1'b0, rem_ff}) : signed'({1'b0, rem_ff});
endmodule

// ----- rtl/core/pts_datapath.sv -----
// ----------------------------------------------------------------------------
// pts_datapath
// Operand registers, root search, shared multiplier and descent terms.
// ----------------------------------------------------------------------------
module pts_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pts_pkg::cmd_type              cmd,
   input  logic [pts_pkg::PRIME_W-1:0]   req_prime,
   output pts_pkg::sts_type              sts,
   output logic signed [pts_pkg::ROOT_W-1:0] rsp_root_a,
   output logic signed [pts_pkg::ROOT_W-1:0] rsp_root_b,
   output logic                          rsp_found
);
   import pts_pkg::*;

   logic [PRIME_BITS-1:0]    p_ff, p_in;
   logic [X_W-1:0]           x_ff, x_in;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic [PRIME_BITS-1:0]    acc_ff, acc_in;
   logic [PRIME_BITS-1:0]    base_ff, base_in;
   logic                     found_ff, found_in;
   logic signed [TERM_W-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [TERM_W-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [TERM_W-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [PRIME_BITS-1:0]    m_ff, m_in;
   logic signed [NUM_W-1:0]  prod_ff, prod_in, s_ff, s_in;
   logic signed [ROOT_W-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic                     rf_ff, rf_in;

   logic [PRIME_BITS-1:0]    e, half, root, mm_a, mm_b, mm_res;
   logic                     mm_start, mm_done;
   logic                     div_start, div_done;
   logic signed [NUM_W-1:0]  div_num, div_quo;
   logic [PRIME_BITS-1:0]    div_den;
   logic signed [PRIME_BITS:0]   div_rem, m_s, cen0, cen1;
   logic signed [PRIME_BITS+1:0] cen2;
   logic signed [TERM_W-1:0] cen, mx, my;

   pts_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .modulus (p_ff),
      .opa     (mm_a),
      .opb     (mm_b),
      .done    (mm_done),
      .result  (mm_res)
   );

   pts_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   always_comb begin
      e    = (p_ff - 1'b1) >> 2;
      half = (p_ff - 1'b1) >> 1;
      root = (acc_ff <= half) ? acc_ff : p_ff - acc_ff;

      mm_start = (cmd.op == OP_MM_ACC) || (cmd.op == OP_MM_BASE) || (cmd.op == OP_MM_SQ);
      mm_a     = (cmd.op == OP_MM_BASE) ? base_ff : acc_ff;
      mm_b     = (cmd.op == OP_MM_ACC || cmd.op == OP_MM_BASE) ? base_ff : acc_ff;

      div_start = (cmd.op == OP_DIV_S) || (cmd.op == OP_DIV_A) || (cmd.op == OP_DIV_B);
      div_num   = (cmd.op == OP_DIV_A) ? NUM_W'(a_ff) :
                  (cmd.op == OP_DIV_B) ? NUM_W'(b_ff) : s_ff;
      div_den   = (cmd.op == OP_DIV_S && cmd.k == K_INIT) ? p_ff : m_ff;

      m_s  = signed'({1'b0, m_ff});
      cen0 = (div_rem < 0) ? div_rem + m_s : div_rem;
      cen2 = {cen0, 1'b0};
      cen1 = (cen2 > signed'({2'b0, m_ff})) ? cen0 - m_s : cen0;
      cen  = TERM_W'(cen1);

      unique case (cmd.k)
         K_NA: begin
            mx = cmd.t ? v_ff : u_ff;
            my = cmd.t ? b_ff : a_ff;
         end
         K_NB: begin
            mx = cmd.t ? v_ff : u_ff;
            my = cmd.t ? a_ff : b_ff;
         end
         K_NM: begin
            mx = cmd.t ? v_ff : u_ff;
            my = mx;
         end
         default: begin
            mx = a_ff;
            my = a_ff;
         end
      endcase
   end

   always_comb begin
      p_in     = p_ff;
      x_in     = x_ff;
      i_in     = i_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      found_in = found_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      m_in     = m_ff;
      prod_in  = prod_ff;
      s_in     = s_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      rf_in    = rf_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            p_in     = req_prime[PRIME_BITS-1:0];
            x_in     = X_W'(1);
            a_in     = '0;
            b_in     = TERM_W'(1);
            found_in = 1'b0;
         end
         OP_POW_INIT: begin
            acc_in  = PRIME_BITS'(1);
            base_in = PRIME_BITS'(x_ff);
            i_in    = '0;
         end
         OP_SET_ACC:  acc_in = mm_res;
         OP_SET_BASE: begin
            base_in = mm_res;
            i_in    = i_ff + 1'b1;
         end
         OP_ROOT: begin
            found_in = 1'b1;
            a_in     = TERM_W'(root);
            b_in     = TERM_W'(1);
         end
         OP_NEXT_X: x_in = x_ff + 1'b1;
         OP_MUL:    prod_in = NUM_W'(mx * my);
         OP_SUM: begin
            if (cmd.k == K_INIT) begin
               s_in = prod_ff + NUM_W'(1);
            end else if (!cmd.t) begin
               s_in = prod_ff;
            end else if (cmd.k == K_NB) begin
               s_in = s_ff - prod_ff;
            end else begin
               s_in = s_ff + prod_ff;
            end
         end
         OP_WR_Q: begin
            unique case (cmd.k)
               K_NA: na_in = TERM_W'(div_quo);
               K_NB: nb_in = TERM_W'(div_quo);
               K_NM: begin
                  m_in = PRIME_BITS'(div_quo);
                  a_in = na_ff;
                  b_in = nb_ff;
               end
               default: m_in = PRIME_BITS'(div_quo);
            endcase
         end
         OP_WR_U: u_in = cen;
         OP_WR_V: v_in = cen;
         OP_EMIT: begin
            ra_in = ROOT_W'(a_ff);
            rb_in = ROOT_W'(b_ff);
            rf_in = found_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      x_ff     <= x_in;
      i_ff     <= i_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      found_ff <= found_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      na_ff    <= na_in;
      nb_ff    <= nb_in;
      m_ff     <= m_in;
      prod_ff  <= prod_in;
      s_ff     <= s_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rf_ff    <= rf_in;
   end

   always_comb begin
      sts.p_lt2    = p_ff < PRIME_BITS'(2);
      sts.x_end    = (x_ff >= X_W'(SEARCH_LIMIT)) || (32'(x_ff) >= 32'(p_ff));
      sts.e_bit    = e[i_ff];
      sts.i_last   = i_ff == CNT_W'(PRIME_BITS - 1);
      sts.mm_done  = mm_done;
      sts.mm_root  = mm_res == p_ff - 1'b1;
      sts.div_done = div_done;
      sts.m_le1    = m_ff <= PRIME_BITS'(1);
   end

   assign rsp_root_a = ra_ff;
   assign rsp_root_b = rb_ff;
   assign rsp_found  = rf_ff;
endmodule

// ----- rtl/core/pts_ctrl.sv -----
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: root search, exponentiation, descent and result handshake.
// ----------------------------------------------------------------------------
module pts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pts_pkg::sts_type sts,
   output pts_pkg::cmd_type cmd
);
   import pts_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_SRCH    = 5'd1;
   localparam logic [4:0] S_POW_A   = 5'd2;
   localparam logic [4:0] S_WAIT_A  = 5'd3;
   localparam logic [4:0] S_POW_B   = 5'd4;
   localparam logic [4:0] S_WAIT_B  = 5'd5;
   localparam logic [4:0] S_SQ      = 5'd6;
   localparam logic [4:0] S_WAIT_SQ = 5'd7;
   localparam logic [4:0] S_MUL0    = 5'd8;
   localparam logic [4:0] S_SUM0    = 5'd9;
   localparam logic [4:0] S_MUL1    = 5'd10;
   localparam logic [4:0] S_SUM1    = 5'd11;
   localparam logic [4:0] S_DIV     = 5'd12;
   localparam logic [4:0] S_DWAIT   = 5'd13;
   localparam logic [4:0] S_LOOP    = 5'd14;
   localparam logic [4:0] S_WU      = 5'd15;
   localparam logic [4:0] S_DIVB    = 5'd16;
   localparam logic [4:0] S_WV      = 5'd17;
   localparam logic [4:0] S_DONE    = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic       rv_ff, rv_in;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      rv_in    = rv_ff && !rsp_ready;
      cmd.op   = OP_NONE;
      cmd.k    = k_ff;
      cmd.t    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.p_lt2 || sts.x_end) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_POW_INIT;
               state_in = S_POW_A;
            end
         end
         S_POW_A: begin
            if (sts.e_bit) begin
               cmd.op   = OP_MM_ACC;
               state_in = S_WAIT_A;
            end else begin
               state_in = S_POW_B;
            end
         end
         S_WAIT_A: begin
            if (sts.mm_done) begin
               cmd.op   = OP_SET_ACC;
               state_in = S_POW_B;
            end
         end
         S_POW_B: begin
            cmd.op   = OP_MM_BASE;
            state_in = S_WAIT_B;
         end
         S_WAIT_B: begin
            if (sts.mm_done) begin
               cmd.op   = OP_SET_BASE;
               state_in = sts.i_last ? S_SQ : S_POW_A;
            end
         end
         S_SQ: begin
            cmd.op   = OP_MM_SQ;
            state_in = S_WAIT_SQ;
         end
         S_WAIT_SQ: begin
            if (sts.mm_done) begin
               if (sts.mm_root) begin
                  cmd.op   = OP_ROOT;
                  k_in     = K_INIT;
                  state_in = S_MUL0;
               end else begin
                  cmd.op   = OP_NEXT_X;
                  state_in = S_SRCH;
               end
            end
         end
         S_MUL0: begin
            cmd.op   = OP_MUL;
            state_in = S_SUM0;
         end
         S_SUM0: begin
            cmd.op   = OP_SUM;
            state_in = (k_ff == K_INIT) ? S_DIV : S_MUL1;
         end
         S_MUL1: begin
            cmd.op   = OP_MUL;
            cmd.t    = 1'b1;
            state_in = S_SUM1;
         end
         S_SUM1: begin
            cmd.op   = OP_SUM;
            cmd.t    = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op   = OP_DIV_S;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               cmd.op = OP_WR_Q;
               if (k_ff == K_INIT || k_ff == K_NM) begin
                  state_in = S_LOOP;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_MUL0;
               end
            end
         end
         S_LOOP: begin
            if (sts.m_le1) begin
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_DIV_A;
               state_in = S_WU;
            end
         end
         S_WU: begin
            if (sts.div_done) begin
               cmd.op   = OP_WR_U;
               state_in = S_DIVB;
            end
         end
         S_DIVB: begin
            cmd.op   = OP_DIV_B;
            state_in = S_WV;
         end
         S_WV: begin
            if (sts.div_done) begin
               cmd.op   = OP_WR_V;
               k_in     = K_NA;
               state_in = S_MUL0;
            end
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               cmd.op   = OP_EMIT;
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= K_NA;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         rv_ff    <= rv_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rv_ff;
endmodule

// ----- rtl/core/prime_two_squares_decomposition.sv -----
// ----------------------------------------------------------------------------
// prime_two_squares_decomposition
// Splits a prime p below 2^31 into a and b with a*a + b*b = p.
// ----------------------------------------------------------------------------
// One item at a time. Each candidate x costs a modular exponentiation of 31
// steps, each squaring the base and, for a set exponent bit, first
// multiplying the accumulator by the base; a squaring check follows. Every
// modular product is bit-serial. The descent then forms M and runs its
// steps on the serial divider. The time that a prime equal to 1 mod 4 takes
// is set by the number of candidates and descent steps. No root of -1 (p
// below two, p equal to 3 mod 4, or none found for x below 128) gives
// a = 0, b = 1, found = 0; such an input tries every x below 128 and
// below p. A new item is taken while the last result still waits in the
// output register.
// ----------------------------------------------------------------------------
module prime_two_squares_decomposition (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pts_pkg::PRIME_W-1:0]       req_prime,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pts_pkg::ROOT_W-1:0] rsp_root_a,
   output logic signed [pts_pkg::ROOT_W-1:0] rsp_root_b,
   output logic                              rsp_found
);
   import pts_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pts_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_prime  (req_prime),
      .sts        (sts),
      .rsp_root_a (rsp_root_a),
      .rsp_root_b (rsp_root_b),
      .rsp_found  (rsp_found)
   );
endmodule

// ----- rtl/core/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks on the two-squares block, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [pts_pkg::ROOT_W-1:0] rsp_root_a,
   input logic signed [pts_pkg::ROOT_W-1:0] rsp_root_b,
   input logic                              rsp_found
);
   import pts_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root_a)
         && $stable(rsp_root_b) && $stable(rsp_found))
      else $error("result changed while stalled");

   a_no_root: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_root_a == ROOT_W'(0) && rsp_root_b == ROOT_W'(1))
      else $error("no-root result not (0,1)");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after accept");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");
endmodule

bind prime_two_squares_decomposition pts_checker u_pts_checker (.*);

// ----- tb/pts_checker.sv -----
// ----------------------------------------------------------------------------
// pts_scoreboard
// Watches both channels of the prime two-squares block, works out the
// expected a, b and found for every accepted prime and compares each result
// item with the oldest expected one, in order.
// ----------------------------------------------------------------------------
module pts_scoreboard (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [pts_pkg::PRIME_W-1:0] req_prime,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [pts_pkg::ROOT_W-1:0]  rsp_root_a,
   input  logic [pts_pkg::ROOT_W-1:0]  rsp_root_b,
   input  logic                        rsp_found,
   output int                          fail_count,
   output int                          pending
);
   import pts_pkg::*;

   typedef struct {
      logic [ROOT_W-1:0] a;
      logic [ROOT_W-1:0] b;
      logic              found;
   } split_type;

   split_type split_q[$];

   function automatic longint unsigned pow_mod(longint unsigned x, longint unsigned e,
                                               longint unsigned m);
      longint unsigned acc;
      longint unsigned base;
      acc  = 1 % m;
      base = x % m;
      for (int i = 0; i < PRIME_BITS; i++) begin
         if (e[i]) acc = (acc * base) % m;
         base = (base * base) % m;
      end
      return acc;
   endfunction

   function automatic longint centre(longint v, longint m);
      longint r;
      r = v % m;
      if (r < 0) r += m;
      if (r * 2 > m) r -= m;
      return r;
   endfunction

   function automatic split_type two_squares(logic [PRIME_W-1:0] prime);
      split_type       res;
      longint unsigned p;
      longint unsigned e;
      longint unsigned y;
      longint unsigned root;
      bit              ok;
      longint          a, b, m, u, v, na, nb;
      p  = prime;
      ok = 0;
      a  = 0;
      b  = 1;
      if (p >= 2) begin
         e = (p - 1) / 4;
         for (longint unsigned x = 1; x < p && x < SEARCH_LIMIT && !ok; x++) begin
            y = pow_mod(x, e, p);
            if ((y * y) % p == p - 1) begin
               ok   = 1;
               root = (y <= (p - 1) / 2) ? y : p - y;
            end
         end
      end
      if (ok) begin
         a = root;
         b = 1;
         m = (a * a + b * b) / longint'(p);
         while (m > 1) begin
            u  = centre(a, m);
            v  = centre(b, m);
            na = (u * a + v * b) / m;
            nb = (u * b - v * a) / m;
            m  = (u * u + v * v) / m;
            a  = na;
            b  = nb;
         end
      end
      res.a     = a[ROOT_W-1:0];
      res.b     = b[ROOT_W-1:0];
      res.found = ok;
      return res;
   endfunction

   always @(posedge clock) begin
      split_type exp_s;
      int        errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) split_q.push_back(two_squares(req_prime));
         if (rsp_valid && rsp_ready) begin
            if (split_q.size() == 0) begin
               $error("unexpected result item a=%0d b=%0d", rsp_root_a, rsp_root_b);
               errs = errs + 1;
            end else begin
               exp_s = split_q.pop_front();
               if (rsp_root_a !== exp_s.a) begin
                  $error("root_a: expected %h, got %h", exp_s.a, rsp_root_a);
                  errs = errs + 1;
               end
               if (rsp_root_b !== exp_s.b) begin
                  $error("root_b: expected %h, got %h", exp_s.b, rsp_root_b);
                  errs = errs + 1;
               end
               if (rsp_found !== exp_s.found) begin
                  $error("found: expected %b, got %b", exp_s.found, rsp_found);
                  errs = errs + 1;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending    <= split_q.size();
      end
   end

endmodule

// ----- tb/tb_prime_two_squares_decomposition.sv -----
// ----------------------------------------------------------------------------
// tb_prime_two_squares_decomposition
// Drives primes and other values into the two-squares block under several
// idle and stall patterns; the scoreboard predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_prime_two_squares_decomposition;
   import pts_pkg::*;

   localparam int N_RAND = 150;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic [PRIME_W-1:0]       req_prime = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic signed [ROOT_W-1:0] rsp_root_a;
   logic signed [ROOT_W-1:0] rsp_root_b;
   logic                     rsp_found;
   int                       fail_count;
   int                       pending;
   int                       send_idle = 0;
   int                       rsp_stall = 0;

   int unsigned p_dir[] = '{0, 1, 2, 3, 5, 7, 13, 17, 29, 21, 25, 65, 97, 1105, 1000000009};

   prime_two_squares_decomposition u_dut (.*);

   pts_scoreboard u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_prime(req_prime),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_root_a(rsp_root_a), .rsp_root_b(rsp_root_b), .rsp_found(rsp_found),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_stall);

   function automatic bit is_prime(int unsigned n);
      if (n < 2) return 0;
      for (int unsigned d = 2; d * d <= n; d++)
         if (n % d == 0) return 0;
      return 1;
   endfunction

   function automatic int unsigned rand_prime(int w);
      int unsigned n;
      do begin
         n = $urandom_range((32'd1 << w) - 1, 32'd1 << (w - 1));
         n = (n & ~32'd3) | 32'd1;
      end while (!is_prime(n));
      return n;
   endfunction

   task automatic send(int unsigned p);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_prime <= p[PRIME_W-1:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic set_phase(int ph);
      case (ph)
         0: begin send_idle = 0;  rsp_stall = 0;  end
         1: begin send_idle = 60; rsp_stall = 0;  end
         2: begin send_idle = 0;  rsp_stall = 60; end
         default: begin send_idle = 14; rsp_stall = 14; end
      endcase
   endtask

   initial begin
      int unsigned big;
      int unsigned p;
      int          k;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      big = 32'h7FFF_FFFD;
      while (!is_prime(big)) big -= 4;
      foreach (p_dir[i]) send(p_dir[i]);
      send(big);
      send(32'h7FFF_FFFF);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      for (int i = 0; i < N_RAND; i++) begin
         set_phase(i * 4 / N_RAND);
         k = $urandom_range(99);
         if (k < 65)      p = rand_prime($urandom_range(31, 3));
         else if (k < 97) p = $urandom_range(255);
         else             p = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000) | 32'd1;
         send(p);
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #1_000_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
